[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also runs through reset.
`define ASSERT_NXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ffpx_pkg.sv]
`timescale 1ns / 1ps

package ffpx_pkg;

    localparam int unsigned CNT_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned N_COLORS  = 5;

    // byte positions of the check byte, the two start bytes, the source byte and the first color byte
    localparam logic [CNT_W-1:0] CHECK_POS       = 4'd8;
    localparam logic [CNT_W-1:0] START_ONE_POS   = 4'd0;
    localparam logic [CNT_W-1:0] START_TWO_POS   = 4'd1;
    localparam logic [CNT_W-1:0] SOURCE_POS      = 4'd2;
    localparam logic [CNT_W-1:0] COLOR_FIRST_POS = 4'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd2;

    localparam logic [7:0] START_ONE_RST   = 8'hA5;
    localparam logic [7:0] START_TWO_RST   = 8'h5A;
    localparam logic [7:0] COLOR_COUNT_RST = 8'd8;
    localparam logic [7:0] SOURCE_MAX      = 8'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_START_BAD = 3'd2,
        ST_INVALID   = 3'd3,
        ST_CHECKSUM  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] start_one;
        logic [7:0] start_two;
        logic [7:0] color_count;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic       frame_src;
        logic [7:0] body_color;
        logic [7:0] center_color;
        logic [7:0] ball_color_a;
        logic [7:0] ball_color_b;
        logic [7:0] ball_color_c;
    } t_result;

endpackage

[sv/ffpx_cfg_regs.sv]
`timescale 1ns / 1ps

module ffpx_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffpx_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]                     i_cfg_wdata,
    output ffpx_pkg::t_cfg                 o_cfg
);

    ffpx_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_one   <= ffpx_pkg::START_ONE_RST;
            r_cfg.start_two   <= ffpx_pkg::START_TWO_RST;
            r_cfg.color_count <= ffpx_pkg::COLOR_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ffpx_pkg::REG_START_ONE:   r_cfg.start_one   <= i_cfg_wdata;
                ffpx_pkg::REG_START_TWO:   r_cfg.start_two   <= i_cfg_wdata;
                ffpx_pkg::REG_COLOR_COUNT: r_cfg.color_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/ffpx_parser.sv]
`timescale 1ns / 1ps

module ffpx_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffpx_pkg::t_cfg   i_cfg,
    input  logic             i_en,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output ffpx_pkg::t_result o_res
);

    logic [ffpx_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]                 r_xor, n_xor;
    logic                       r_hdr_bad, n_hdr_bad;
    logic [7:0]                 r_src, n_src;
    logic [7:0]                 r_colors [ffpx_pkg::N_COLORS];
    logic [7:0]                 n_colors [ffpx_pkg::N_COLORS];
    logic                       r_drain, n_drain;

    logic              col_bad;
    ffpx_pkg::t_status verdict;
    logic              restart;

    // frame check on the ninth byte
    always_comb begin
        if (r_src == 8'd0) begin
            col_bad = (r_colors[0] >= i_cfg.color_count) ||
                      (r_colors[1] >= i_cfg.color_count);
        end else begin
            col_bad = (r_colors[2] >= i_cfg.color_count) ||
                      (r_colors[3] >= i_cfg.color_count) ||
                      (r_colors[4] >= i_cfg.color_count);
        end
        if (r_hdr_bad) begin
            verdict = ffpx_pkg::ST_START_BAD;
        end else if (r_src > ffpx_pkg::SOURCE_MAX || col_bad) begin
            verdict = ffpx_pkg::ST_INVALID;
        end else if (r_xor != i_data_byte) begin
            verdict = ffpx_pkg::ST_CHECKSUM;
        end else begin
            verdict = ffpx_pkg::ST_OK;
        end
    end

    always_comb begin
        n_count   = r_count;
        n_xor     = r_xor;
        n_hdr_bad = r_hdr_bad;
        n_src     = r_src;
        n_drain   = r_drain;
        for (int i = 0; i < ffpx_pkg::N_COLORS; i++) begin
            n_colors[i] = r_colors[i];
        end
        restart      = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.status = ffpx_pkg::ST_OK;

        if (i_en) begin
            if (r_drain) begin
                restart = i_last_byte;
            end else if (r_count != ffpx_pkg::CHECK_POS) begin
                if (r_count == ffpx_pkg::START_ONE_POS && i_data_byte != i_cfg.start_one) begin
                    n_hdr_bad = 1'b1;
                end
                if (r_count == ffpx_pkg::START_TWO_POS && i_data_byte != i_cfg.start_two) begin
                    n_hdr_bad = 1'b1;
                end
                if (r_count == ffpx_pkg::SOURCE_POS) begin
                    n_src = i_data_byte;
                end
                for (int i = 0; i < ffpx_pkg::N_COLORS; i++) begin
                    if (r_count == ffpx_pkg::COLOR_FIRST_POS + ffpx_pkg::CNT_W'(i)) begin
                        n_colors[i] = i_data_byte;
                    end
                end
                n_xor   = r_xor ^ i_data_byte;
                n_count = r_count + 1'b1;
                if (i_last_byte) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ffpx_pkg::ST_TOO_SHORT;
                    restart      = 1'b1;
                end
            end else begin
                o_res_valid  = 1'b1;
                o_res.status = verdict;
                if (verdict == ffpx_pkg::ST_OK) begin
                    o_res.frame_src = r_src[0];
                    if (r_src == 8'd0) begin
                        o_res.body_color   = r_colors[0];
                        o_res.center_color = r_colors[1];
                    end else begin
                        o_res.ball_color_a = r_colors[2];
                        o_res.ball_color_b = r_colors[3];
                        o_res.ball_color_c = r_colors[4];
                    end
                end
                restart = i_last_byte;
                n_drain = !i_last_byte;
            end
        end

        if (restart) begin
            n_count   = '0;
            n_xor     = '0;
            n_hdr_bad = 1'b0;
            n_src     = '0;
            n_drain   = 1'b0;
            for (int i = 0; i < ffpx_pkg::N_COLORS; i++) begin
                n_colors[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_xor     <= '0;
            r_hdr_bad <= 1'b0;
            r_src     <= '0;
            r_drain   <= 1'b0;
            for (int i = 0; i < ffpx_pkg::N_COLORS; i++) begin
                r_colors[i] <= '0;
            end
        end else begin
            r_count   <= n_count;
            r_xor     <= n_xor;
            r_hdr_bad <= n_hdr_bad;
            r_src     <= n_src;
            r_drain   <= n_drain;
            for (int i = 0; i < ffpx_pkg::N_COLORS; i++) begin
                r_colors[i] <= n_colors[i];
            end
        end
    end

endmodule

[sv/ffpx_out_reg.sv]
`timescale 1ns / 1ps

module ffpx_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  ffpx_pkg::t_result i_res,
    input  logic              i_tready,
    output logic              o_adv,
    output logic              o_valid,
    output ffpx_pkg::t_result o_res
);

    logic              r_valid;
    ffpx_pkg::t_result r_res;

    // the stage ahead may move whenever this register is empty or being drained
    assign o_adv = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[sv/fixed_frame_parser_xor_check_top.sv]
`timescale 1ns / 1ps

// Fixed 9-byte frame parser with XOR check byte.
// Input stream: one buffer byte per transfer on s_axis_tdata[7:0], s_axis_tlast on the
// final byte of a buffer. Frame: two start bytes, source byte, five color bytes,
// check byte (XOR of bytes 0..7). The ninth byte, or tlast before it, yields one
// result on m_axis (source flag on m_axis_tuser); later bytes give nothing until
// tlast, which restarts the frame.
// Configuration: write strobe i_cfg_we with i_cfg_addr 0 start byte one, 1 start
// byte two, 2 color count; takes effect on the next byte processed.
// Path: a byte moves into the input register, the parser works on it from there, and
// its result is captured in the output register that drives m_axis.
// Throughput: one byte per cycle while no held result stalls the output register; the
// parser sits between the input and the result registers.
// Reset (synchronous, active low): frame state cleared, registers back to A5/5A/8,
// both channels empty.
// Stall: a held result keeps the parser frozen; s_axis_tready drops once the input
// register holds a byte, so one more byte lands there only if it was empty.
module fixed_frame_parser_xor_check_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] status, [10:3] body_color, [18:11] center_color, [26:19] ball_color_a,
    // [34:27] ball_color_b, [42:35] ball_color_c, [47:43] zero
    output logic [47:0]                    m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] frame_src
    input  logic                           i_cfg_we,
    input  logic [ffpx_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]                     i_cfg_wdata
);

    ffpx_pkg::t_cfg    cfg;
    ffpx_pkg::t_result res;
    ffpx_pkg::t_result out_res;
    logic              res_valid;
    logic              adv;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    ffpx_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ffpx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_en        (r_in_valid && adv),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ffpx_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_tready    (m_axis_tready),
        .o_adv       (adv),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {5'b00000, out_res.ball_color_c, out_res.ball_color_b,
                           out_res.ball_color_a, out_res.center_color, out_res.body_color,
                           out_res.status};
    assign m_axis_tuser = out_res.frame_src;

endmodule

[sv/ffpx_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffpx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // no result is shown right after reset
    `ASSERT_NXT_NR(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // a stalled result holds
    `ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // status is one of the five codes, padding is zero
    `ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid,
                m_axis_tdata[2:0] <= ffpx_pkg::ST_CHECKSUM && m_axis_tdata[47:43] == 5'd0)

    // a failed frame carries nothing but its status
    `ASSERT_IMP(a_fail_zero, i_clk, i_rst_n,
                m_axis_tvalid && m_axis_tdata[2:0] != ffpx_pkg::ST_OK,
                m_axis_tdata[42:3] == 40'd0 && !m_axis_tuser)

    // an ok source-0 result has no ball colors, an ok source-1 result no body/center
    `ASSERT_IMP(a_ok_fields, i_clk, i_rst_n,
                m_axis_tvalid && m_axis_tdata[2:0] == ffpx_pkg::ST_OK,
                (m_axis_tuser ? (m_axis_tdata[18:3] == 16'd0)
                              : (m_axis_tdata[42:19] == 24'd0)))

endmodule

bind fixed_frame_parser_xor_check_top ffpx_checker u_ffpx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
